// ===== sv/utf8_to_utf16_decoder_unit_defines.svh =====
// Assertion macros for the file that checks its own logic.
`ifndef UTF8_TO_UTF16_DECODER_UNIT_DEFINES_SVH
`define UTF8_TO_UTF16_DECODER_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define U8U16_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("u8u16 same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define U8U16_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("u8u16 next-cycle check failed");

`endif

// ===== sv/u8u16_pkg.sv =====
`default_nettype none

package u8u16_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned UNIT_W    = 16;
  localparam int unsigned MAX_UNITS = 3;
  localparam int unsigned NUM_W     = 2;
  localparam int unsigned VAL_W     = 21;
  localparam int unsigned CNT_W     = 2;

  localparam logic [UNIT_W-1:0] SURR_HI_OFS = 16'hD7C0;
  localparam logic [UNIT_W-1:0] SURR_LO_OFS = 16'hDC00;

  localparam logic [CNT_W-1:0] CLS_NONE  = 2'd0;
  localparam logic [CNT_W-1:0] CLS_TWO   = 2'd1;
  localparam logic [CNT_W-1:0] CLS_THREE = 2'd2;
  localparam logic [CNT_W-1:0] CLS_FOUR  = 2'd3;

  typedef struct packed {
    logic [MAX_UNITS-1:0][UNIT_W-1:0] unit;
    logic [NUM_W-1:0]                 num;
  } res_t;

  function automatic logic [CNT_W-1:0] lead_class(input logic [BYTE_W-1:0] b);
    logic [CNT_W-1:0] cls;
    cls = CLS_NONE;
    if (b[7:5] == 3'b110) begin
      cls = CLS_TWO;
    end else if (b[7:4] == 4'b1110) begin
      cls = CLS_THREE;
    end else if (b[7:3] == 5'b11110) begin
      cls = CLS_FOUR;
    end
    return cls;
  endfunction

endpackage

`default_nettype wire

// ===== sv/u8u16_in_if.sv =====
`default_nettype none

interface u8u16_in_if import u8u16_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              string_end;

  modport source (output valid, output data_byte, output string_end, input ready);
  modport sink (input valid, input data_byte, input string_end, output ready);
endinterface

`default_nettype wire

// ===== sv/u8u16_out_if.sv =====
`default_nettype none

interface u8u16_out_if import u8u16_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [UNIT_W-1:0] code_unit;
  logic              run_end;

  modport source (output valid, output code_unit, output run_end, input ready);
  modport sink (input valid, input code_unit, input run_end, output ready);
endinterface

`default_nettype wire

// ===== sv/u8u16_step.sv =====
`default_nettype none

module u8u16_step import u8u16_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              fire_i,
  input  wire logic [BYTE_W-1:0] data_byte_i,
  input  wire logic              string_end_i,
  output res_t                   res_o
);

  logic [BYTE_W-1:0] lead_q, lead_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  needed_q, needed_d;
  logic [BYTE_W-1:0] follow_q [2];
  logic              fw_en;
  logic              fw_idx;
  logic [VAL_W-1:0]  val;
  logic [BYTE_W-1:0] first;
  logic [CNT_W-1:0]  cls;
  res_t              res;

  always_comb begin
    res      = '0;
    lead_d   = lead_q;
    count_d  = count_q;
    needed_d = needed_q;
    fw_en    = 1'b0;
    fw_idx   = count_q[0];
    first    = follow_q[0];
    cls      = lead_class(data_byte_i);
    val      = '0;
    case (needed_q)
      CLS_TWO: val = {10'd0, lead_q[4:0], data_byte_i[5:0]};
      CLS_THREE: val = {5'd0, lead_q[3:0], follow_q[0][5:0], data_byte_i[5:0]};
      default: val = {lead_q[2:0], follow_q[0][5:0], follow_q[1][5:0], data_byte_i[5:0]};
    endcase

    if (needed_q == CLS_NONE) begin
      if (cls == CLS_NONE || string_end_i) begin
        res.unit[0] = {8'd0, data_byte_i};
        res.num     = 2'd1;
      end else begin
        lead_d   = data_byte_i;
        needed_d = cls;
        count_d  = '0;
      end
    end else if (({1'b0, count_q} + 3'd1) >= {1'b0, needed_q}) begin
      if (val[VAL_W-1:UNIT_W] != '0) begin
        res.unit[0] = {5'd0, val[VAL_W-1:10]} + SURR_HI_OFS;
        res.unit[1] = {6'd0, val[9:0]} + SURR_LO_OFS;
        res.num     = 2'd2;
      end else begin
        res.unit[0] = val[UNIT_W-1:0];
        res.num     = 2'd1;
      end
      lead_d   = '0;
      count_d  = '0;
      needed_d = CLS_NONE;
    end else if (string_end_i) begin
      res.unit[0] = {8'd0, lead_q};
      if (count_q == '0) begin
        res.unit[1] = {8'd0, data_byte_i};
        res.num     = 2'd2;
      end else if (lead_class(first) == CLS_TWO) begin
        res.unit[1] = {5'd0, first[4:0], data_byte_i[5:0]};
        res.num     = 2'd2;
      end else begin
        res.unit[1] = {8'd0, first};
        res.unit[2] = {8'd0, data_byte_i};
        res.num     = 2'd3;
      end
      lead_d   = '0;
      count_d  = '0;
      needed_d = CLS_NONE;
    end else begin
      fw_en   = 1'b1;
      count_d = count_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lead_q   <= '0;
      count_q  <= '0;
      needed_q <= CLS_NONE;
    end else if (fire_i) begin
      lead_q   <= lead_d;
      count_q  <= count_d;
      needed_q <= needed_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i && fw_en) begin
      follow_q[fw_idx] <= data_byte_i;
    end
  end

  assign res_o = res;

endmodule

`default_nettype wire

// ===== sv/u8u16_obuf.sv =====
`default_nettype none

module u8u16_obuf import u8u16_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              fire_i,
  input  res_t                   res_i,
  output logic                   free_o,
  output logic                   valid_o,
  input  wire logic              ready_i,
  output logic [UNIT_W-1:0]      code_unit_o,
  output logic                   run_end_o
);

  logic [MAX_UNITS-1:0][UNIT_W-1:0] unit_q, unit_d;
  logic [NUM_W-1:0]                 cnt_q, cnt_d;
  logic                             pop;

  assign valid_o     = (cnt_q != '0);
  assign pop         = valid_o && ready_i;
  assign free_o      = (cnt_q == '0) || (cnt_q == 2'd1 && ready_i);
  assign code_unit_o = unit_q[0];
  assign run_end_o   = (cnt_q == 2'd1);

  always_comb begin
    unit_d = unit_q;
    cnt_d  = cnt_q;
    if (pop) begin
      for (int i = 0; i < MAX_UNITS - 1; i++) begin
        unit_d[i] = unit_q[i + 1];
      end
      cnt_d = cnt_q - 2'd1;
    end
    if (fire_i && res_i.num != '0) begin
      unit_d = res_i.unit;
      cnt_d  = res_i.num;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    unit_q <= unit_d;
  end

endmodule

`default_nettype wire

// ===== sv/utf8_to_utf16_decoder_unit.sv =====
// UTF-8 to UTF-16 transcoder.
// The in_i channel carries one UTF-8 byte per beat with a string_end flag;
// the out_o channel carries one UTF-16 code unit per beat, with run_end set
// on the last unit that a given input byte produced.
// A byte is decoded in the cycle it is accepted against the held sequence
// state, and its zero to three code units land in the result register, so
// the first unit is offered in the cycle after the byte is taken.
// A byte that yields at most one unit can follow every cycle while out_o
// is ready, for a throughput of one byte per clock. A byte with k units
// holds the result register until all k are taken, as the output drains
// one unit per beat; bytes that extend a sequence produce no beat at all.
// Reset closes any open sequence and empties the result register.
// When the receiver stalls, the pending unit holds and in_i.ready stays low
// until the last unit of the current byte is taken; ready comes back in the
// same cycle that last unit is accepted.
`default_nettype none
`include "utf8_to_utf16_decoder_unit_defines.svh"

module utf8_to_utf16_decoder_unit import u8u16_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  u8u16_in_if.sink   in_i,
  u8u16_out_if.source out_o
);

  logic fire;
  logic free;
  res_t res;

  assign in_i.ready = free;
  assign fire       = in_i.valid && free;

  u8u16_step u_step (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (fire),
    .data_byte_i  (in_i.data_byte),
    .string_end_i (in_i.string_end),
    .res_o        (res)
  );

  u8u16_obuf u_obuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .res_i       (res),
    .free_o      (free),
    .valid_o     (out_o.valid),
    .ready_i     (out_o.ready),
    .code_unit_o (out_o.code_unit),
    .run_end_o   (out_o.run_end)
  );

  `U8U16_ASSERT_NXT(a_load_shows_first, clk_i, rst_ni, fire && res.num != '0, out_o.valid && out_o.code_unit == $past(res.unit[0]))
  `U8U16_ASSERT_NXT(a_hold_no_beat, clk_i, rst_ni, fire && res.num == '0 && !(out_o.valid && !out_o.ready), !out_o.valid)
  `U8U16_ASSERT_IMP(a_ready_only_last, clk_i, rst_ni, in_i.ready && out_o.valid, out_o.run_end && out_o.ready)

endmodule

`default_nettype wire
